@@ hdl/tht_pkg.sv @@
// ----------------------------------------------------------------------------
// tht_pkg
// Shared types and constants for the triangle hit test table: field widths,
// command codes, the stored entry layout and the area unit control/status.
// ----------------------------------------------------------------------------
package tht_pkg;

    // Field widths
    localparam int COORD_W = 16;
    localparam int ID_W    = 32;
    localparam int TOL_W   = 20;
    localparam int CMD_W   = 2;
    localparam int DIFF_W  = COORD_W + 1;      // coordinate difference
    localparam int PROD_W  = 2 * DIFF_W;       // one cross product term
    localparam int AREA_W  = PROD_W + 1;       // signed doubled area
    localparam int SUM_W   = AREA_W + 2;       // s1 + s2 + s3 - whole

    // Defaults
    localparam int              MAX_TRIANGLES_DEF = 64;
    localparam logic [TOL_W-1:0] TOL_RESET        = 20'd6711;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Result id when nothing was hit
    localparam logic [ID_W-1:0] ID_NONE = '1;

    // Steps per entry: four areas, two products each
    localparam logic [2:0] STEP_LAST = 3'd7;

    // One table row
    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
    } t_entry;

    // Sequencer to area unit
    typedef struct packed {
        logic       issue;
        logic [2:0] step;   // [2:1] area select, [0] product half
    } t_unit_ctl;

    // Area unit to sequencer
    typedef struct packed {
        logic                    done;
        logic signed [SUM_W-1:0] sum;
    } t_unit_sts;

endpackage

@@ hdl/tht_if.sv @@
// ----------------------------------------------------------------------------
// tht_req_if / tht_rsp_if
// Valid/ready channels carrying command requests and their responses.
// ----------------------------------------------------------------------------
interface tht_req_if;
    logic                                valid;
    logic                                ready;
    logic [tht_pkg::CMD_W-1:0]           cmd;
    logic signed [tht_pkg::ID_W-1:0]     touch_id;
    logic signed [tht_pkg::COORD_W-1:0]  ax;
    logic signed [tht_pkg::COORD_W-1:0]  ay;
    logic signed [tht_pkg::COORD_W-1:0]  bx;
    logic signed [tht_pkg::COORD_W-1:0]  by;
    logic signed [tht_pkg::COORD_W-1:0]  cx;
    logic signed [tht_pkg::COORD_W-1:0]  cy;
    logic signed [tht_pkg::COORD_W-1:0]  point_x;
    logic signed [tht_pkg::COORD_W-1:0]  point_y;

    modport source (
        output valid, cmd, touch_id, ax, ay, bx, by, cx, cy, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, cmd, touch_id, ax, ay, bx, by, cx, cy, point_x, point_y,
        output ready
    );
endinterface

interface tht_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            found;
    logic signed [tht_pkg::ID_W-1:0] hit_id;
    logic                            table_full;

    modport source (output valid, found, hit_id, table_full, input ready);
    modport sink   (input  valid, found, hit_id, table_full, output ready);
endinterface

@@ hdl/triangle_hit_test_table.sv @@
// ----------------------------------------------------------------------------
// triangle_hit_test_table
// Table of touch triangles with an area-sum point hit test, newest first.
// ----------------------------------------------------------------------------
// Insert, clear and unknown commands: a taken request goes to ST_DONE, which
// loads the response register once it is free and returns to ST_IDLE.
// Query: per entry tested, a table read (ST_LOAD), 8 product steps on the
// shared multiplier (ST_CALC), area pipeline drain (ST_WAIT); newest first.
// One request in flight; a new request is taken while a response waits.
// Synchronous active-low reset empties the table and restores the tolerance.
// ----------------------------------------------------------------------------
module triangle_hit_test_table #(
    parameter int MAX_TRIANGLES = tht_pkg::MAX_TRIANGLES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tht_req_if.sink                        i_req,
    tht_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [tht_pkg::TOL_W-1:0]      i_cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
    localparam int IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CALC,
        ST_WAIT,
        ST_DONE
    } t_state;

    t_state                              r_state, n_state;
    logic [CNT_W-1:0]                    r_count, n_count;
    logic [tht_pkg::TOL_W-1:0]           r_tol, n_tol;
    logic [IDX_W-1:0]                    r_idx, n_idx;
    logic [2:0]                          r_step, n_step;
    logic signed [tht_pkg::COORD_W-1:0]  r_px, n_px, r_py, n_py;
    logic                                r_found, n_found;
    logic [tht_pkg::ID_W-1:0]            r_hit, n_hit;
    logic                                r_full, n_full;
    logic                                r_o_valid, n_o_valid;
    logic                                r_o_found, n_o_found;
    logic [tht_pkg::ID_W-1:0]            r_o_hit, n_o_hit;
    logic                                r_o_full, n_o_full;

    tht_pkg::t_entry                     mem [MAX_TRIANGLES];
    tht_pkg::t_entry                     r_rd;
    tht_pkg::t_entry                     wr_entry;
    logic                                mem_we;
    logic                                req_acc;
    logic                                hit;
    logic signed [tht_pkg::SUM_W-1:0]    tol_s;
    tht_pkg::t_unit_ctl                  unit_ctl;
    tht_pkg::t_unit_sts                  unit_sts;

    assign req_acc     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);

    assign wr_entry = '{id: i_req.touch_id, x0: i_req.ax, y0: i_req.ay,
                        x1: i_req.bx, y1: i_req.by, x2: i_req.cx, y2: i_req.cy};

    // Table memory: one write port for inserts, registered read for the walk
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[IDX_W-1:0]] <= wr_entry;
        end
        r_rd <= mem[r_idx];
    end

    // Shared area unit
    assign unit_ctl.issue = (r_state == ST_CALC);
    assign unit_ctl.step  = r_step;

    tht_area_unit u_area (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (r_rd),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_ctl   (unit_ctl),
        .o_sts   (unit_sts)
    );

    // Hit when |sum - whole| < tolerance
    assign tol_s = {{(tht_pkg::SUM_W - tht_pkg::TOL_W){1'b0}}, r_tol};
    assign hit   = (unit_sts.sum < tol_s) && (unit_sts.sum > -tol_s);

    // Sequencer next state
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_tol     = i_cfg_we ? i_cfg_wdata : r_tol;
        n_idx     = r_idx;
        n_step    = r_step;
        n_px      = r_px;
        n_py      = r_py;
        n_found   = r_found;
        n_hit     = r_hit;
        n_full    = r_full;
        n_o_valid = r_o_valid && !o_rsp.ready;
        n_o_found = r_o_found;
        n_o_hit   = r_o_hit;
        n_o_full  = r_o_full;
        mem_we    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    n_found = 1'b0;
                    n_hit   = tht_pkg::ID_NONE;
                    n_full  = 1'b0;
                    n_state = ST_DONE;
                    case (i_req.cmd)
                        tht_pkg::CMD_INSERT: begin
                            if (r_count >= CNT_W'(MAX_TRIANGLES)) begin
                                n_full = 1'b1;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        tht_pkg::CMD_QUERY: begin
                            n_px = i_req.point_x;
                            n_py = i_req.point_y;
                            if (r_count != '0) begin
                                n_idx   = IDX_W'(r_count - 1'b1);
                                n_state = ST_LOAD;
                            end
                        end
                        tht_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                n_step  = '0;
                n_state = ST_CALC;
            end
            ST_CALC: begin
                n_step = r_step + 1'b1;
                if (r_step == tht_pkg::STEP_LAST) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (unit_sts.done) begin
                    if (hit) begin
                        n_found = 1'b1;
                        n_hit   = r_rd.id;
                        n_state = ST_DONE;
                    end else if (r_idx == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_DONE: begin
                // Move the result into the output register once it is free
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid = 1'b1;
                    n_o_found = r_found;
                    n_o_hit   = r_hit;
                    n_o_full  = r_full;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_tol     <= tht_pkg::TOL_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_tol     <= n_tol;
            r_o_valid <= n_o_valid;
        end
        r_idx     <= n_idx;
        r_step    <= n_step;
        r_px      <= n_px;
        r_py      <= n_py;
        r_found   <= n_found;
        r_hit     <= n_hit;
        r_full    <= n_full;
        r_o_found <= n_o_found;
        r_o_hit   <= n_o_hit;
        r_o_full  <= n_o_full;
    end

    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.found      = r_o_found;
    assign o_rsp.hit_id     = r_o_hit;
    assign o_rsp.table_full = r_o_full;

endmodule

@@ hdl/tht_area_unit.sv @@
// ----------------------------------------------------------------------------
// tht_area_unit
// Shared multiply/accumulate pipeline. Each issued step forms one cross
// product term of one of the four doubled areas; the unit folds them into
// s1 + s2 + s3 - whole and pulses done after the last step of an entry.
// ----------------------------------------------------------------------------
module tht_area_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tht_pkg::t_entry                   i_entry,
    input  logic signed [tht_pkg::COORD_W-1:0] i_px,
    input  logic signed [tht_pkg::COORD_W-1:0] i_py,
    input  tht_pkg::t_unit_ctl                i_ctl,
    output tht_pkg::t_unit_sts                o_sts
);

    typedef struct packed {
        logic       half;
        logic [1:0] area;
        logic       last;
    } t_tag;

    logic signed [tht_pkg::COORD_W-1:0] p1x, p1y, p2x, p2y, p3x, p3y;
    logic signed [tht_pkg::DIFF_W-1:0]  n_opa, n_opb;
    logic signed [tht_pkg::SUM_W-1:0]   area_ext, sum_base;
    logic                               area_add;

    logic                               r_a_vld, r_b_vld, r_c_vld, r_done;
    t_tag                               r_a_tag, r_b_tag;
    logic [1:0]                         r_c_area;
    logic                               r_c_last;
    logic signed [tht_pkg::DIFF_W-1:0]  r_opa, r_opb;
    logic signed [tht_pkg::PROD_W-1:0]  r_prod, r_term;
    logic signed [tht_pkg::AREA_W-1:0]  r_area;
    logic signed [tht_pkg::SUM_W-1:0]   r_sum;

    // Vertices: area 0 as stored, area N puts the point at vertex N
    always_comb begin
        p1x = i_entry.x0;  p1y = i_entry.y0;
        p2x = i_entry.x1;  p2y = i_entry.y1;
        p3x = i_entry.x2;  p3y = i_entry.y2;
        case (i_ctl.step[2:1])
            2'd1: begin
                p1x = i_px;  p1y = i_py;
            end
            2'd2: begin
                p2x = i_px;  p2y = i_py;
            end
            2'd3: begin
                p3x = i_px;  p3y = i_py;
            end
            default: begin
            end
        endcase
    end

    // Operand differences: (x2-x1)*(y3-y1) first, then (x3-x1)*(y2-y1)
    always_comb begin
        if (!i_ctl.step[0]) begin
            n_opa = {p2x[15], p2x} - {p1x[15], p1x};
            n_opb = {p3y[15], p3y} - {p1y[15], p1y};
        end else begin
            n_opa = {p3x[15], p3x} - {p1x[15], p1x};
            n_opb = {p2y[15], p2y} - {p1y[15], p1y};
        end
    end

    // Accumulate |area|: whole area restarts the sum negatively
    always_comb begin
        area_ext = tht_pkg::SUM_W'(r_area);
        if (r_c_area == 2'd0) begin
            area_add = r_area[tht_pkg::AREA_W-1];
            sum_base = '0;
        end else begin
            area_add = !r_area[tht_pkg::AREA_W-1];
            sum_base = r_sum;
        end
    end

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_a_vld <= i_ctl.issue;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld && r_b_tag.half;
            r_done  <= r_c_vld && r_c_last;
        end
    end

    // Pipeline data
    always_ff @(posedge i_clk) begin
        r_a_tag <= '{half: i_ctl.step[0], area: i_ctl.step[2:1],
                     last: (i_ctl.step == tht_pkg::STEP_LAST)};
        r_opa   <= n_opa;
        r_opb   <= n_opb;

        r_b_tag <= r_a_tag;
        r_prod  <= r_opa * r_opb;

        if (r_b_vld && !r_b_tag.half) begin
            r_term <= r_prod;
        end
        r_area   <= tht_pkg::AREA_W'(r_term) - tht_pkg::AREA_W'(r_prod);
        r_c_area <= r_b_tag.area;
        r_c_last <= r_b_tag.last;

        if (r_c_vld) begin
            r_sum <= area_add ? sum_base + area_ext : sum_base - area_ext;
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.sum  = r_sum;

endmodule

@@ hdl/tht_checker.sv @@
// ----------------------------------------------------------------------------
// tht_checker
// Port-level checks on the triangle hit test table, bound to the top level.
// ----------------------------------------------------------------------------
module tht_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_req_valid,
    input logic                      i_req_ready,
    input logic                      i_rsp_valid,
    input logic                      i_rsp_ready,
    input logic                      i_found,
    input logic [tht_pkg::ID_W-1:0]  i_hit_id,
    input logic                      i_table_full
);

    // A stalled response keeps its contents
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_found) && $stable(i_hit_id)
            && $stable(i_table_full))
        else $error("response changed while stalled");

    // One request at a time: taking one drops ready
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while busy");

    // A miss reports the no-hit id
    a_miss_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_found |-> i_hit_id == tht_pkg::ID_NONE)
        else $error("miss without no-hit id");

    // A refused insert is never also a hit
    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_table_full |-> !i_found)
        else $error("table_full together with found");

endmodule

bind triangle_hit_test_table tht_checker u_tht_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_found      (o_rsp.found),
    .i_hit_id     (o_rsp.hit_id),
    .i_table_full (o_rsp.table_full)
);
